FILE: rtl/rsqv_pkg.sv
// Shared types and constants for the rotated sprite quad vertex generator.
`timescale 1ns / 1ps

package rsqv_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE       = 2'd2;

    // Reset values of the configuration registers
    localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd320;
    localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd240;
    localparam logic [7:0]  RST_PALETTE       = 8'd0;

    // Quarter-wave sine polynomial coefficients, Q16
    localparam logic [16:0] POLY_A = 17'd102944;
    localparam logic [16:0] POLY_B = 17'd42048;
    localparam logic [16:0] POLY_C = 17'd4640;
    localparam logic [16:0] Q_ONE  = 17'd65536;

    // One sprite request after setup, handed from front to back
    typedef struct packed {
        logic signed [17:0] sin_v;
        logic signed [17:0] cos_v;
        logic signed [16:0] px;
        logic signed [16:0] py;
        logic signed [16:0] dx0;
        logic signed [16:0] dx1;
        logic signed [16:0] dy0;
        logic signed [16:0] dy1;
        logic signed [18:0] u0;
        logic signed [18:0] u1;
        logic signed [18:0] v0;
        logic signed [18:0] v1;
    } sprite_t;

endpackage

FILE: rtl/rsqv_front.sv
// Front end: accepts a sprite request, sets up offsets and computes sine and cosine.
`timescale 1ns / 1ps

module rsqv_front #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [15:0]   dest_x,
    input  logic signed [15:0]   dest_y,
    input  logic signed [15:0]   span_w,
    input  logic signed [15:0]   span_h,
    input  logic signed [15:0]   source_x,
    input  logic signed [15:0]   source_y,
    input  logic [9:0]           atlas_x,
    input  logic [9:0]           atlas_y,
    input  logic signed [15:0]   pivot_x,
    input  logic signed [15:0]   pivot_y,
    input  logic [15:0]          turn_angle,
    input  logic                 q_full,
    output logic                 q_push,
    output rsqv_pkg::sprite_t    q_data
);

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_PUSH} state_t;

    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    state_t                  state_reg, state_next;
    logic [2:0]              step_reg, step_next;
    logic                    phase_reg, phase_next;
    logic [ANGLE_BITS-1:0]   angle_reg;
    logic [16:0]             x_reg, x2_reg, x3_reg, x5_reg;
    logic signed [35:0]      acc_reg;
    rsqv_pkg::sprite_t       item_reg;

    logic                    accept;
    logic [ANGLE_BITS-1:0]   ang_eff;
    logic [1:0]              quad;
    logic [16:0]             x_base, x_cur;
    logic [16:0]             mul_a, mul_b;
    logic [33:0]             prod;
    logic signed [35:0]      v_sum, v_pos;
    logic [19:0]             v_rnd;
    logic [16:0]             v_mag;
    logic signed [17:0]      trig_v;
    logic signed [18:0]      u0_in, v0_in;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign q_push = (state_reg == S_PUSH) && !q_full;
    assign q_data = item_reg;

    // Fold the angle into a quadrant and a position inside it
    always_comb
    begin
        ang_eff = phase_reg ? (angle_reg + QUARTER) : angle_reg;
        quad    = ang_eff[ANGLE_BITS-1:ANGLE_BITS-2];
        x_base  = 17'(ang_eff[ANGLE_BITS-3:0]) << (18 - ANGLE_BITS);
        x_cur   = quad[0] ? (rsqv_pkg::Q_ONE - x_base) : x_base;
    end

    // Pick multiplier operands for the current polynomial step
    always_comb
    begin
        case (step_reg)
            3'd0:    begin mul_a = x_cur;            mul_b = x_cur;  end
            3'd1:    begin mul_a = x_reg;            mul_b = x2_reg; end
            3'd2:    begin mul_a = x3_reg;           mul_b = x2_reg; end
            3'd3:    begin mul_a = rsqv_pkg::POLY_A; mul_b = x_reg;  end
            3'd4:    begin mul_a = rsqv_pkg::POLY_B; mul_b = x3_reg; end
            3'd5:    begin mul_a = rsqv_pkg::POLY_C; mul_b = x5_reg; end
            default: begin mul_a = '0;               mul_b = '0;     end
        endcase
        prod = mul_a * mul_b;
    end

    // Finish the polynomial: round, limit to one and apply the quadrant sign
    always_comb
    begin
        v_sum  = acc_reg + $signed({2'b00, prod});
        v_pos  = (v_sum < 0) ? 36'sd0 : v_sum;
        v_rnd  = 20'((v_pos + 36'sd32768) >>> 16);
        v_mag  = (v_rnd > 20'd65536) ? rsqv_pkg::Q_ONE : v_rnd[16:0];
        trig_v = quad[1] ? -$signed({1'b0, v_mag}) : $signed({1'b0, v_mag});
    end

    assign u0_in = $signed({9'b0, atlas_x}) + 19'(source_x);
    assign v0_in = $signed({9'b0, atlas_y}) + 19'(source_y);

    // Step the sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CALC;
                    step_next  = 3'd0;
                    phase_next = 1'b0;
                end
            end
            S_CALC:
            begin
                if (step_reg == 3'd5)
                begin
                    step_next = 3'd0;
                    if (phase_reg)
                        state_next = S_PUSH;
                    else
                        phase_next = 1'b1;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            S_PUSH:
            begin
                if (!q_full)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= 3'd0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
        end
    end

    // Capture the request and the polynomial terms
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            angle_reg     <= turn_angle[ANGLE_BITS-1:0];
            item_reg.px   <= 17'(dest_x) + 17'(pivot_x);
            item_reg.py   <= 17'(dest_y) + 17'(pivot_y);
            item_reg.dx0  <= -17'(pivot_x);
            item_reg.dx1  <= 17'(span_w) - 17'(pivot_x);
            item_reg.dy0  <= -17'(pivot_y);
            item_reg.dy1  <= 17'(span_h) - 17'(pivot_y);
            item_reg.u0   <= u0_in;
            item_reg.u1   <= u0_in + 19'(span_w);
            item_reg.v0   <= v0_in;
            item_reg.v1   <= v0_in + 19'(span_h);
        end
        if (state_reg == S_CALC)
        begin
            case (step_reg)
                3'd0:
                begin
                    x_reg  <= x_cur;
                    x2_reg <= prod[32:16];
                end
                3'd1:    x3_reg  <= prod[32:16];
                3'd2:    x5_reg  <= prod[32:16];
                3'd3:    acc_reg <= $signed({2'b00, prod});
                3'd4:    acc_reg <= acc_reg - $signed({2'b00, prod});
                3'd5:
                begin
                    if (phase_reg)
                        item_reg.cos_v <= trig_v;
                    else
                        item_reg.sin_v <= trig_v;
                end
                default: acc_reg <= acc_reg;
            endcase
        end
    end

endmodule

FILE: rtl/rsqv_queue.sv
// Two-entry queue of set-up sprite requests between front and back.
`timescale 1ns / 1ps

module rsqv_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rsqv_pkg::sprite_t    push_data,
    input  logic                 pop,
    output rsqv_pkg::sprite_t    pop_data,
    output logic                 full,
    output logic                 empty
);

    rsqv_pkg::sprite_t  slot_reg [2];
    logic               wr_ptr_reg, rd_ptr_reg;
    logic [1:0]         count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Advance pointers and level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    // Store the request
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: rtl/rsqv_div.sv
// Restoring divider, one quotient bit a cycle, with an overflow flag.
`timescale 1ns / 1ps

module rsqv_div #(
    parameter int DW = 56,
    parameter int QB = 33
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DW-1:0]    dividend,
    input  logic [12:0]      den,
    output logic             busy,
    output logic             ovf,
    output logic [QB-1:0]    quot
);

    localparam int CW = $clog2(QB + 1);

    logic            busy_reg;
    logic [CW-1:0]   count_reg;
    logic [12:0]     rem_reg;
    logic [QB-1:0]   lo_reg;
    logic [QB-1:0]   quot_reg;
    logic            ovf_reg;

    logic [DW-1:0]   top_part;
    logic            is_ovf;
    logic [13:0]     trial;
    logic            fits;

    assign busy = busy_reg;
    assign ovf  = ovf_reg;
    assign quot = quot_reg;

    always_comb
    begin
        top_part = dividend >> QB;
        is_ovf   = (top_part >= DW'(den));
        trial    = {rem_reg, lo_reg[QB-1]};
        fits     = (trial >= {1'b0, den});
    end

    // Track the iteration count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= is_ovf ? '0 : CW'(QB);
        end
        else if (busy_reg)
        begin
            if (count_reg == '0)
                busy_reg <= 1'b0;
            else
                count_reg <= count_reg - CW'(1);
        end
    end

    // Shift in one dividend bit and subtract when it fits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ovf_reg  <= is_ovf;
            rem_reg  <= is_ovf ? 13'd0 : top_part[12:0];
            lo_reg   <= dividend[QB-1:0];
            quot_reg <= '0;
        end
        else if (busy_reg && (count_reg != '0))
        begin
            rem_reg  <= fits ? 13'(trial - {1'b0, den}) : trial[12:0];
            lo_reg   <= lo_reg << 1;
            quot_reg <= {quot_reg[QB-2:0], fits};
        end
    end

endmodule

FILE: rtl/rsqv_back.sv
// Back end: rotates each corner, normalizes it and emits four vertices.
`timescale 1ns / 1ps

module rsqv_back #(
    parameter int FRAC_BITS      = 16,
    parameter int TEX_SCALE_LOG2 = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  rsqv_pkg::sprite_t    q_data,
    output logic                 q_pop,
    input  logic [12:0]          w_eff,
    input  logic [12:0]          h_eff,
    input  logic [7:0]           palette,
    output logic                 strobe,
    output logic signed [31:0]   screen_x,
    output logic signed [31:0]   screen_y,
    output logic signed [17:0]   tex_u,
    output logic signed [17:0]   tex_v,
    output logic [7:0]           vertex_palette,
    output logic [1:0]           corner,
    output logic                 last_corner
);

    typedef enum logic [2:0] {B_IDLE, B_MUL, B_SUM, B_GO, B_WAIT} state_t;

    localparam int XW   = 37;
    localparam int NUMW = 40 + FRAC_BITS;
    localparam int QB   = 33;
    localparam logic signed [35:0] FONE = 36'sd1 <<< FRAC_BITS;
    localparam logic signed [35:0] S32_MAX = 36'sd2147483647;
    localparam logic signed [35:0] S32_MIN = -36'sd2147483648;

    state_t                  state_reg, state_next;
    logic [1:0]              corner_reg;
    rsqv_pkg::sprite_t       item_reg;
    logic signed [34:0]      pa_reg, pb_reg, pc_reg, pd_reg;
    logic [NUMW-1:0]         magx_reg, magy_reg;
    logic                    negx_reg, negy_reg;
    logic signed [17:0]      tu_reg, tv_reg;

    logic                    strobe_reg;
    logic signed [31:0]      sx_reg, sy_reg;
    logic signed [17:0]      ou_reg, ov_reg;
    logic [7:0]              pal_reg;
    logic [1:0]              ocorner_reg;

    logic signed [16:0]      dx, dy;
    logic signed [18:0]      tu_sel, tv_sel;
    logic signed [XW-1:0]    xr, yr;
    logic signed [NUMW-1:0]  numx, numy;
    logic [NUMW-1:0]         magx, magy;
    logic [29:0]             denx, deny;
    logic signed [17:0]      tu_val, tv_val;
    logic                    div_go;
    logic                    bx, by, ox, oy;
    logic [QB-1:0]           qx, qy;
    logic signed [35:0]      qxs, qys, nx_full, ny_full;
    logic signed [31:0]      nx, ny;
    logic                    done;

    // Texel to atlas units with rounding and saturation
    function automatic logic signed [17:0] tex_coord(input logic signed [18:0] t);
        logic signed [29:0] n;
        logic signed [29:0] s;
        n = (30'(t) <<< 10) + (30'sd1 <<< (TEX_SCALE_LOG2 - 1));
        s = n >>> TEX_SCALE_LOG2;
        if (s > 30'sd131071)
            return 18'sd131071;
        else if (s < -30'sd131072)
            return -18'sd131072;
        else
            return s[17:0];
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > S32_MAX)
            return 32'sh7FFFFFFF;
        else if (v < S32_MIN)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // Select the corner of the quad
    always_comb
    begin
        dx     = corner_reg[1] ? item_reg.dx1 : item_reg.dx0;
        dy     = corner_reg[0] ? item_reg.dy0 : item_reg.dy1;
        tu_sel = corner_reg[1] ? item_reg.u1  : item_reg.u0;
        tv_sel = corner_reg[0] ? item_reg.v0  : item_reg.v1;
    end

    // Build the rounded-division numerators and their magnitudes
    always_comb
    begin
        xr   = XW'(pa_reg) - XW'(pb_reg) + (XW'(item_reg.px) <<< 16);
        yr   = XW'(pc_reg) + XW'(pd_reg) + (XW'(item_reg.py) <<< 16);
        denx = {w_eff, 17'b0};
        deny = {h_eff, 17'b0};
        numx = (NUMW'(xr) <<< (FRAC_BITS + 2)) + NUMW'($signed({1'b0, w_eff, 16'h0000}));
        numy = (NUMW'(yr) <<< (FRAC_BITS + 2)) + NUMW'($signed({1'b0, h_eff, 16'h0000}));
        magx = (numx < 0) ? (NUMW'(-numx) + NUMW'(denx) - NUMW'(1)) : NUMW'(numx);
        magy = (numy < 0) ? (NUMW'(-numy) + NUMW'(deny) - NUMW'(1)) : NUMW'(numy);
        tu_val = tex_coord(tu_sel);
        tv_val = tex_coord(tv_sel);
    end

    assign div_go = (state_reg == B_GO);

    rsqv_div #(.DW(NUMW), .QB(QB)) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go),
        .dividend (magx_reg >> 17),
        .den      (w_eff),
        .busy     (bx),
        .ovf      (ox),
        .quot     (qx)
    );

    rsqv_div #(.DW(NUMW), .QB(QB)) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go),
        .dividend (magy_reg >> 17),
        .den      (h_eff),
        .busy     (by),
        .ovf      (oy),
        .quot     (qy)
    );

    // Apply signs, offset by one and saturate
    always_comb
    begin
        qxs     = negx_reg ? -36'($signed({1'b0, qx})) : 36'($signed({1'b0, qx}));
        qys     = negy_reg ? -36'($signed({1'b0, qy})) : 36'($signed({1'b0, qy}));
        nx_full = qxs - FONE;
        ny_full = FONE - qys;
        if (ox)
            nx = negx_reg ? 32'sh80000000 : 32'sh7FFFFFFF;
        else
            nx = sat32(nx_full);
        if (oy)
            ny = negy_reg ? 32'sh7FFFFFFF : 32'sh80000000;
        else
            ny = sat32(ny_full);
    end

    assign done  = (state_reg == B_WAIT) && !bx && !by;
    assign q_pop = (state_reg == B_IDLE) && !q_empty;

    // Step through the four corners
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (!q_empty) state_next = B_MUL;
            B_MUL:   state_next = B_SUM;
            B_SUM:   state_next = B_GO;
            B_GO:    state_next = B_WAIT;
            B_WAIT:
            begin
                if (done)
                    state_next = (corner_reg == 2'd3) ? B_IDLE : B_MUL;
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Hold state and the vertex strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            corner_reg <= 2'd0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= done;
            if (q_pop)
                corner_reg <= 2'd0;
            else if (done)
                corner_reg <= corner_reg + 2'd1;
        end
    end

    // Register products, numerators and the vertex
    always_ff @(posedge clk)
    begin
        if (q_pop)
            item_reg <= q_data;
        if (state_reg == B_MUL)
        begin
            pa_reg <= dx * item_reg.cos_v;
            pb_reg <= dy * item_reg.sin_v;
            pc_reg <= dx * item_reg.sin_v;
            pd_reg <= dy * item_reg.cos_v;
        end
        if (state_reg == B_SUM)
        begin
            magx_reg <= magx;
            magy_reg <= magy;
            negx_reg <= (numx < 0);
            negy_reg <= (numy < 0);
            tu_reg   <= tu_val;
            tv_reg   <= tv_val;
        end
        if (done)
        begin
            sx_reg      <= nx;
            sy_reg      <= ny;
            ou_reg      <= tu_reg;
            ov_reg      <= tv_reg;
            pal_reg     <= palette;
            ocorner_reg <= corner_reg;
        end
    end

    assign strobe         = strobe_reg;
    assign screen_x       = sx_reg;
    assign screen_y       = sy_reg;
    assign tex_u          = ou_reg;
    assign tex_v          = ov_reg;
    assign vertex_palette = pal_reg;
    assign corner         = ocorner_reg;
    assign last_corner    = (ocorner_reg == 2'd3);

endmodule

FILE: rtl/rotated_sprite_quad_vertices.sv
// Top level of the rotated sprite quad vertex generator.
`timescale 1ns / 1ps

// A sprite request is taken when start is high and busy is low; busy stays
// high while the front end evaluates sine and cosine with one shared
// multiplier and waits for room in the queue, then drops so the next
// request can be taken while earlier sprites sit in a two-entry queue or are
// being drawn. The back end produces four vertices per sprite, one strobe
// cycle each, in the order (x1,y2), (x1,y1), (x2,y2), (x2,y1). Each vertex
// waits on the pair of one-bit-per-cycle dividers that normalize x and y,
// which finish early when a coordinate saturates. Vertices cannot be held
// off: take them on the strobe. Write configuration only while the block
// is idle.
module rotated_sprite_quad_vertices #(
    parameter int ANGLE_BITS     = 16,
    parameter int FRAC_BITS      = 16,
    parameter int TEX_SCALE_LOG2 = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [12:0]          cfg_data,
    input  logic signed [15:0]   dest_x,
    input  logic signed [15:0]   dest_y,
    input  logic signed [15:0]   span_w,
    input  logic signed [15:0]   span_h,
    input  logic signed [15:0]   source_x,
    input  logic signed [15:0]   source_y,
    input  logic [9:0]           atlas_x,
    input  logic [9:0]           atlas_y,
    input  logic signed [15:0]   pivot_x,
    input  logic signed [15:0]   pivot_y,
    input  logic [15:0]          turn_angle,
    output logic                 strobe,
    output logic signed [31:0]   screen_x,
    output logic signed [31:0]   screen_y,
    output logic signed [17:0]   tex_u,
    output logic signed [17:0]   tex_v,
    output logic [7:0]           vertex_palette,
    output logic [1:0]           corner,
    output logic                 last_corner
);

    logic [12:0]          width_reg, height_reg;
    logic [7:0]           palette_reg;
    logic [12:0]          w_eff, h_eff;

    logic                 q_push, q_pop, q_full, q_empty;
    rsqv_pkg::sprite_t    push_data, pop_data;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= rsqv_pkg::RST_SCREEN_WIDTH;
            height_reg  <= rsqv_pkg::RST_SCREEN_HEIGHT;
            palette_reg <= rsqv_pkg::RST_PALETTE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rsqv_pkg::REG_SCREEN_WIDTH:  width_reg   <= cfg_data;
                rsqv_pkg::REG_SCREEN_HEIGHT: height_reg  <= cfg_data;
                rsqv_pkg::REG_PALETTE:       palette_reg <= cfg_data[7:0];
                default:                     palette_reg <= palette_reg;
            endcase
        end
    end

    // Treat a zero resolution as one
    assign w_eff = (width_reg  == 13'd0) ? 13'd1 : width_reg;
    assign h_eff = (height_reg == 13'd0) ? 13'd1 : height_reg;

    rsqv_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .dest_x     (dest_x),
        .dest_y     (dest_y),
        .span_w     (span_w),
        .span_h     (span_h),
        .source_x   (source_x),
        .source_y   (source_y),
        .atlas_x    (atlas_x),
        .atlas_y    (atlas_y),
        .pivot_x    (pivot_x),
        .pivot_y    (pivot_y),
        .turn_angle (turn_angle),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (push_data)
    );

    rsqv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    rsqv_back #(.FRAC_BITS(FRAC_BITS), .TEX_SCALE_LOG2(TEX_SCALE_LOG2)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_data         (pop_data),
        .q_pop          (q_pop),
        .w_eff          (w_eff),
        .h_eff          (h_eff),
        .palette        (palette_reg),
        .strobe         (strobe),
        .screen_x       (screen_x),
        .screen_y       (screen_y),
        .tex_u          (tex_u),
        .tex_v          (tex_v),
        .vertex_palette (vertex_palette),
        .corner         (corner),
        .last_corner    (last_corner)
    );

`ifndef SYNTHESIS
    // An accepted request keeps the front end busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) start && !busy |=> busy)
        else $error("front end not busy after request");

    // Vertices are never back to back: each needs its own divide
    assert property (@(posedge clk) disable iff (!rst_n) strobe |=> !strobe)
        else $error("vertex strobe held for two cycles");

    // The front end never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_full))
        else $error("push into full queue");

    // The back end pops only when a request is waiting
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("pop from empty queue");
`endif

endmodule
